// ===== rtl/robin_hood_uid_lookup_unit_macros.svh =====
// assertion macros shared by the lookup unit
`ifndef ROBIN_HOOD_UID_LOOKUP_UNIT_MACROS_SVH
`define ROBIN_HOOD_UID_LOOKUP_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define RHUL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define RHUL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rhul_pkg.sv =====
package rhul_pkg;

    // field widths
    localparam int unsigned MODE_W     = 1;
    localparam int unsigned UID_W      = 32;
    localparam int unsigned MASK_W     = 10;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned SLOT_MAX_W = 16;

    // s_tdata layout, lowest field first
    localparam int unsigned UID_LSB    = 0;
    localparam int unsigned SIDX_LSB   = UID_LSB + UID_W;
    localparam int unsigned SKEY_LSB   = SIDX_LSB + MASK_W;
    localparam int unsigned SVAL_LSB   = SKEY_LSB + KEY_W;
    localparam int unsigned S_BITS     = SVAL_LSB + VAL_W;
    localparam int unsigned S_TDATA_W  = ((S_BITS + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = VAL_W;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam logic [MASK_W-1:0] MASK_RESET = 10'h3FF;

    // request kinds
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [UID_W-1:0] UID_NONE = 32'hFFFF_FFFF;

    // lowbias32 mixer constants
    localparam logic [31:0] MIX_MUL1 = 32'h7FEB_352D;
    localparam logic [31:0] MIX_MUL2 = 32'h846C_A68B;
    localparam int unsigned MIX_SH1  = 16;
    localparam int unsigned MIX_SH2  = 15;
    localparam int unsigned MIX_SH3  = 16;

    // reduce a masked index to a slot of a table of the given depth
    function automatic logic [SLOT_MAX_W-1:0] slot_of(input logic [MASK_W-1:0] a,
                                                      input int unsigned depth);
        logic [31:0] r;
        r = 32'(a);
        for (int k = MASK_W - 1; k >= 0; k--) begin
            if (r >= (32'(depth) << k)) begin
                r = r - (32'(depth) << k);
            end
        end
        return r[SLOT_MAX_W-1:0];
    endfunction

endpackage

// ===== rtl/rhul_hash.sv =====
module rhul_hash (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rhul_pkg::UID_W-1:0] uid,
    output logic [31:0]               target,
    output logic                      target_valid
);

    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] m1_reg;
    logic [31:0] m1_next;
    logic [31:0] m2_reg;
    logic [31:0] m2_next;
    logic        s1_valid_reg;
    logic        s2_valid_reg;

    // stage 1: add one, fold, first multiply
    assign v0      = uid + 32'd1;
    assign v1      = v0 ^ (v0 >> rhul_pkg::MIX_SH1);
    assign m1_next = v1 * rhul_pkg::MIX_MUL1;

    // stage 2: fold, second multiply
    assign v2      = m1_reg ^ (m1_reg >> rhul_pkg::MIX_SH2);
    assign m2_next = v2 * rhul_pkg::MIX_MUL2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m1_reg <= m1_next;
        m2_reg <= m2_next;
    end

    assign target       = m2_reg ^ (m2_reg >> rhul_pkg::MIX_SH3);
    assign target_valid = s2_valid_reg;

endmodule

// ===== rtl/robin_hood_uid_lookup_unit.sv =====
// write request: written when accepted, a new request may follow in the next cycle
// lookup request: the uid is hashed in ST_HASH, then slots are read and compared in ST_CMP
// until a hit or a stop (at most TABLE_DEPTH slots); a stalled result waits in ST_DONE
// all-ones uid: answered not found through ST_DONE, with no hash and no probe
// reset: synchronous, active low; then a clearing pass over every slot empties
// the key memory while no request is taken (configuration writes are always taken)
`include "robin_hood_uid_lookup_unit_macros.svh"

module robin_hood_uid_lookup_unit #(
    parameter int unsigned TABLE_DEPTH = rhul_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: uid[31:0], slot_index[41:32], slot_key[73:42], slot_value[137:74], zero pad
    input  logic [rhul_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode (0 write slot, 1 lookup)
    input  logic                            s_tuser,
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: value_out[63:0]
    output logic [rhul_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: found
    output logic                            m_tuser,
    // index_mask register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rhul_pkg::MASK_W-1:0]     cfg_data
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // request fields
    logic                          s_mode;
    logic [rhul_pkg::UID_W-1:0]    s_uid;
    logic [rhul_pkg::MASK_W-1:0]   s_slot_index;
    logic [rhul_pkg::KEY_W-1:0]    s_slot_key;
    logic [rhul_pkg::VAL_W-1:0]    s_slot_value;

    assign s_mode       = s_tuser;
    assign s_uid        = s_tdata[rhul_pkg::UID_LSB  +: rhul_pkg::UID_W];
    assign s_slot_index = s_tdata[rhul_pkg::SIDX_LSB +: rhul_pkg::MASK_W];
    assign s_slot_key   = s_tdata[rhul_pkg::SKEY_LSB +: rhul_pkg::KEY_W];
    assign s_slot_value = s_tdata[rhul_pkg::SVAL_LSB +: rhul_pkg::VAL_W];

    // control and datapath registers
    logic [2:0]                    state_reg, state_next;
    logic [ADDR_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0]             probe_cnt_reg, probe_cnt_next;
    logic [rhul_pkg::MASK_W-1:0]   mask_reg;
    logic [rhul_pkg::MASK_W-1:0]   cur_reg, cur_next;
    logic [31:0]                   target_reg, target_next;
    logic                          pend_found_reg, pend_found_next;
    logic [rhul_pkg::VAL_W-1:0]    pend_value_reg, pend_value_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          m_found_reg, m_found_next;
    logic [rhul_pkg::VAL_W-1:0]    m_value_reg, m_value_next;

    // memory ports
    logic [rhul_pkg::KEY_W-1:0]    key_mem [TABLE_DEPTH];
    logic [rhul_pkg::VAL_W-1:0]    val_mem [TABLE_DEPTH];
    logic                          key_we;
    logic                          val_we;
    logic [ADDR_W-1:0]             wr_slot;
    logic [rhul_pkg::KEY_W-1:0]    key_wr_data;
    logic [ADDR_W-1:0]             rd_slot;
    logic [rhul_pkg::KEY_W-1:0]    key_rd_reg;
    logic [rhul_pkg::VAL_W-1:0]    val_rd_reg;

    // hash unit
    logic                          hash_start;
    logic [31:0]                   hash_target;
    logic                          hash_valid;

    // probe decision
    logic                          out_free;
    logic                          hit;
    logic                          stop;
    logic [rhul_pkg::MASK_W-1:0]   dist_target;
    logic [rhul_pkg::MASK_W-1:0]   dist_key;
    logic [rhul_pkg::MASK_W-1:0]   cur_inc;
    logic [rhul_pkg::MASK_W-1:0]   hash_home;

    rhul_hash u_hash (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (hash_start),
        .uid          (s_uid),
        .target       (hash_target),
        .target_valid (hash_valid)
    );

    // the output register frees up this cycle if empty or being taken
    assign out_free = !m_tvalid_reg || m_tready;

    // robin hood distances, both taken under the mask
    assign dist_target = (cur_reg - target_reg[rhul_pkg::MASK_W-1:0]) & mask_reg;
    assign dist_key    = (cur_reg - key_rd_reg[rhul_pkg::MASK_W-1:0]) & mask_reg;

    // key compare before the empty test, so a zero hash can match an empty slot
    assign hit  = (key_rd_reg == target_reg);
    assign stop = (key_rd_reg == '0) || (dist_target > dist_key) ||
                  (probe_cnt_reg == SLOT_LAST);

    assign cur_inc   = (cur_reg + 1'b1) & mask_reg;
    assign hash_home = hash_target[rhul_pkg::MASK_W-1:0] & mask_reg;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        probe_cnt_next  = probe_cnt_reg;
        cur_next        = cur_reg;
        target_next     = target_reg;
        pend_found_next = pend_found_reg;
        pend_value_next = pend_value_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_found_next    = m_found_reg;
        m_value_next    = m_value_reg;
        key_we          = 1'b0;
        val_we          = 1'b0;
        wr_slot         = '0;
        key_wr_data     = s_slot_key;
        rd_slot         = '0;
        hash_start      = 1'b0;

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // one key word emptied per cycle
                key_we      = 1'b1;
                wr_slot     = clr_cnt_reg;
                key_wr_data = '0;
                if (clr_cnt_reg == SLOT_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_mode == rhul_pkg::MODE_WRITE) begin
                        key_we  = 1'b1;
                        val_we  = 1'b1;
                        wr_slot = ADDR_W'(rhul_pkg::slot_of(s_slot_index, TABLE_DEPTH));
                    end else if (s_uid == rhul_pkg::UID_NONE) begin
                        // reserved uid, answered not found without probing
                        pend_found_next = 1'b0;
                        pend_value_next = '0;
                        state_next      = ST_DONE;
                    end else begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                // first probe read issued as soon as the hash lands
                if (hash_valid) begin
                    target_next    = hash_target;
                    cur_next       = hash_home;
                    rd_slot        = ADDR_W'(rhul_pkg::slot_of(hash_home, TABLE_DEPTH));
                    probe_cnt_next = '0;
                    state_next     = ST_CMP;
                end
            end
            ST_CMP: begin
                if (hit || stop) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        m_found_next  = hit;
                        m_value_next  = hit ? val_rd_reg : '0;
                        state_next    = ST_IDLE;
                    end else begin
                        pend_found_next = hit;
                        pend_value_next = hit ? val_rd_reg : '0;
                        state_next      = ST_DONE;
                    end
                end else begin
                    // read of the next slot overlaps this compare
                    cur_next       = cur_inc;
                    rd_slot        = ADDR_W'(rhul_pkg::slot_of(cur_inc, TABLE_DEPTH));
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                // result parked until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = pend_found_reg;
                    m_value_next  = pend_value_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            mask_reg     <= rhul_pkg::MASK_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                mask_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        probe_cnt_reg  <= probe_cnt_next;
        cur_reg        <= cur_next;
        target_reg     <= target_next;
        pend_found_reg <= pend_found_next;
        pend_value_reg <= pend_value_next;
        m_found_reg    <= m_found_next;
        m_value_reg    <= m_value_next;
    end

    // key memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_slot] <= key_wr_data;
        end
        key_rd_reg <= key_mem[rd_slot];
    end

    // value memory, not cleared
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[wr_slot] <= s_slot_value;
        end
        val_rd_reg <= val_mem[rd_slot];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_found_reg;
    assign m_tdata   = m_value_reg;

    `RHUL_ASSERT_NXT(a_lookup_to_hash, aclk, aresetn,
        s_tvalid && s_tready && (s_mode == rhul_pkg::MODE_LOOKUP) && (s_uid != rhul_pkg::UID_NONE),
        state_reg == ST_HASH, "lookup request did not start the hash")
    `RHUL_ASSERT_NXT(a_write_no_result, aclk, aresetn,
        s_tvalid && s_tready && (s_mode == rhul_pkg::MODE_WRITE) && !m_tvalid_reg,
        !m_tvalid_reg, "write request produced a result")
    `RHUL_ASSERT_IMP(a_hash_in_hash_state, aclk, aresetn,
        hash_valid, state_reg == ST_HASH, "hash landed outside the hash state")
    `RHUL_ASSERT_NXT(a_clear_ends, aclk, aresetn,
        (state_reg == ST_CLEAR) && (clr_cnt_reg == SLOT_LAST),
        state_reg == ST_IDLE, "clearing pass did not end on the last slot")

endmodule

// ===== sim/testbench.sv =====
module testbench;

    localparam int TABLE_SLOTS = rhul_pkg::TABLE_DEPTH_DEF;
    localparam logic [rhul_pkg::MASK_W-1:0] MASK_FULL = '1;
    localparam logic [rhul_pkg::MASK_W-1:0] MASK_NONE = '0;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic        found;
        logic [63:0] value;
    } lookup_answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rhul_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rhul_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rhul_pkg::MASK_W-1:0] cfg_data = '0;

    // own copy of the table contents and the mask register
    logic [rhul_pkg::KEY_W-1:0] key_tbl [TABLE_SLOTS];
    logic [rhul_pkg::VAL_W-1:0] val_tbl [TABLE_SLOTS];
    logic [rhul_pkg::MASK_W-1:0] mask_shadow = rhul_pkg::MASK_RESET;

    lookup_answer_t pending_answers [$];
    logic [rhul_pkg::UID_W-1:0] known_uids [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int answers_checked = 0;
    int requests_sent = 0;
    int hits_expected = 0;
    int mask_writes = 0;

    robin_hood_uid_lookup_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            key_tbl[i] = '0;
            val_tbl[i] = '0;
        end
    end

    // lowbias32 mixer applied to uid plus one
    function automatic logic [31:0] lowbias_hash(input logic [rhul_pkg::UID_W-1:0] uid);
        logic [31:0] v;
        v = uid + 32'd1;
        v = v ^ (v >> rhul_pkg::MIX_SH1);
        v = v * rhul_pkg::MIX_MUL1;
        v = v ^ (v >> rhul_pkg::MIX_SH2);
        v = v * rhul_pkg::MIX_MUL2;
        v = v ^ (v >> rhul_pkg::MIX_SH3);
        return v;
    endfunction

    // random slot index of the request field width
    function automatic logic [rhul_pkg::MASK_W-1:0] random_slot();
        logic [31:0] r;
        r = $urandom;
        return r[rhul_pkg::MASK_W-1:0];
    endfunction

    // walk the table the way the engine does and say what it must answer
    function automatic lookup_answer_t resolve_uid(input logic [rhul_pkg::UID_W-1:0] uid);
        lookup_answer_t ans;
        logic [31:0] target;
        logic [31:0] resident;
        logic [rhul_pkg::MASK_W-1:0] cur;
        logic [rhul_pkg::MASK_W-1:0] dist_target;
        logic [rhul_pkg::MASK_W-1:0] dist_resident;
        ans = '{found: 1'b0, value: '0};
        if (uid == rhul_pkg::UID_NONE)
            return ans;
        target = lowbias_hash(uid);
        cur = target[rhul_pkg::MASK_W-1:0] & mask_shadow;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            resident = key_tbl[int'(cur) % TABLE_SLOTS];
            if (resident == target) begin
                ans.found = 1'b1;
                ans.value = val_tbl[int'(cur) % TABLE_SLOTS];
                return ans;
            end
            if (resident == '0)
                return ans;
            dist_target = (cur - target[rhul_pkg::MASK_W-1:0]) & mask_shadow;
            dist_resident = (cur - resident[rhul_pkg::MASK_W-1:0]) & mask_shadow;
            if (dist_target > dist_resident)
                return ans;
            cur = (cur + 1'b1) & mask_shadow;
        end
        return ans;
    endfunction

    // a uid whose hash lands on the given home slot under the current mask
    function automatic logic [rhul_pkg::UID_W-1:0] uid_homed_at(
            input logic [rhul_pkg::MASK_W-1:0] slot);
        logic [rhul_pkg::UID_W-1:0] u;
        logic [31:0] h;
        u = $urandom;
        h = lowbias_hash(u);
        while (u == rhul_pkg::UID_NONE || (h[rhul_pkg::MASK_W-1:0] & mask_shadow) != slot) begin
            u = u + 1'b1;
            h = lowbias_hash(u);
        end
        return u;
    endfunction

    // a key word that sits at its own home slot
    function automatic logic [rhul_pkg::KEY_W-1:0] key_homed_at(
            input logic [rhul_pkg::MASK_W-1:0] slot);
        logic [rhul_pkg::KEY_W-1:0] k;
        k = $urandom;
        k[rhul_pkg::MASK_W-1:0] = slot;
        return k;
    endfunction

    function automatic int occupied_slots();
        int count;
        count = 0;
        for (int s = 0; s < TABLE_SLOTS; s++)
            if ((s[rhul_pkg::MASK_W-1:0] & mask_shadow) == s[rhul_pkg::MASK_W-1:0] &&
                key_tbl[s] != '0)
                count++;
        return count;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s, got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // sends one request and updates the predicted table or answer queue on acceptance
    task automatic push_request(input logic mode, input logic [rhul_pkg::UID_W-1:0] uid,
                                input logic [rhul_pkg::MASK_W-1:0] slot,
                                input logic [rhul_pkg::KEY_W-1:0] key,
                                input logic [rhul_pkg::VAL_W-1:0] value);
        logic [rhul_pkg::S_TDATA_W-1:0] word;
        lookup_answer_t ans;
        word = '0;
        word[rhul_pkg::UID_LSB +: rhul_pkg::UID_W] = uid;
        word[rhul_pkg::SIDX_LSB +: rhul_pkg::MASK_W] = slot;
        word[rhul_pkg::SKEY_LSB +: rhul_pkg::KEY_W] = key;
        word[rhul_pkg::SVAL_LSB +: rhul_pkg::VAL_W] = value;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        s_tuser <= mode;
        do @(posedge aclk); while (s_tready !== 1'b1);
        requests_sent++;
        if (mode == rhul_pkg::MODE_WRITE) begin
            key_tbl[int'(slot) % TABLE_SLOTS] = key;
            val_tbl[int'(slot) % TABLE_SLOTS] = value;
        end else begin
            ans = resolve_uid(uid);
            if (ans.found)
                hits_expected++;
            pending_answers.push_back(ans);
        end
    endtask

    task automatic issue_write(input logic [rhul_pkg::MASK_W-1:0] slot,
                               input logic [rhul_pkg::KEY_W-1:0] key,
                               input logic [rhul_pkg::VAL_W-1:0] value);
        push_request(rhul_pkg::MODE_WRITE, $urandom, slot, key, value);
    endtask

    task automatic issue_lookup(input logic [rhul_pkg::UID_W-1:0] uid);
        push_request(rhul_pkg::MODE_LOOKUP, uid, random_slot(), $urandom,
                     {$urandom, $urandom});
    endtask

    // stop sending until every lookup is answered, then let the engine settle
    task automatic hold_until_answered(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_answers.size() != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_index_mask(input logic [rhul_pkg::MASK_W-1:0] mask);
        hold_until_answered(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data <= mask;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        mask_shadow = mask;
        mask_writes++;
    endtask

    // robin hood insertion: a poorer carried entry displaces a richer resident
    task automatic rh_insert(input logic [rhul_pkg::UID_W-1:0] uid,
                             input logic [rhul_pkg::VAL_W-1:0] value);
        logic [rhul_pkg::KEY_W-1:0] carry_key;
        logic [rhul_pkg::VAL_W-1:0] carry_val;
        logic [rhul_pkg::KEY_W-1:0] resident;
        logic [rhul_pkg::VAL_W-1:0] resident_val;
        logic [rhul_pkg::MASK_W-1:0] cur;
        logic [rhul_pkg::MASK_W-1:0] dist_carry;
        logic [rhul_pkg::MASK_W-1:0] dist_resident;
        carry_key = lowbias_hash(uid);
        carry_val = value;
        cur = carry_key[rhul_pkg::MASK_W-1:0] & mask_shadow;
        for (int n = 0; n <= int'(mask_shadow); n++) begin
            resident = key_tbl[int'(cur) % TABLE_SLOTS];
            if (resident == '0) begin
                issue_write(cur, carry_key, carry_val);
                return;
            end
            dist_carry = (cur - carry_key[rhul_pkg::MASK_W-1:0]) & mask_shadow;
            dist_resident = (cur - resident[rhul_pkg::MASK_W-1:0]) & mask_shadow;
            if (dist_carry > dist_resident) begin
                resident_val = val_tbl[int'(cur) % TABLE_SLOTS];
                issue_write(cur, carry_key, carry_val);
                carry_key = resident;
                carry_val = resident_val;
            end
            cur = (cur + 1'b1) & mask_shadow;
        end
    endtask

    // hand-built probe chains on the full-size table
    task automatic test_lookup_basics();
        logic [rhul_pkg::UID_W-1:0] u;
        set_index_mask(MASK_FULL);
        // empty table, then the reserved all-ones uid
        issue_lookup('0);
        issue_lookup(rhul_pkg::UID_NONE);
        // hit at the home slot, value all ones
        u = uid_homed_at(10'd100);
        issue_write(10'd100, lowbias_hash(u), '1);
        issue_lookup(u);
        // resident with equal probe distance is stepped over
        u = uid_homed_at(10'd200);
        issue_write(10'd200, key_homed_at(10'd200), {$urandom, $urandom});
        issue_write(10'd201, lowbias_hash(u), {$urandom, $urandom});
        issue_lookup(u);
        // richer resident ends the search before the key is reached
        u = uid_homed_at(10'd300);
        issue_write(10'd300, key_homed_at(10'd300), {$urandom, $urandom});
        issue_write(10'd301, key_homed_at(10'd301), {$urandom, $urandom});
        issue_write(10'd302, lowbias_hash(u), {$urandom, $urandom});
        issue_lookup(u);
        // empty slot ends the search
        u = uid_homed_at(10'd400);
        issue_write(10'd400, key_homed_at(10'd400), {$urandom, $urandom});
        issue_write(10'd401, '0, {$urandom, $urandom});
        issue_write(10'd402, lowbias_hash(u), {$urandom, $urandom});
        issue_lookup(u);
        // probe wraps from the top slot to slot zero, value all zeros
        u = uid_homed_at(MASK_FULL);
        issue_write(MASK_FULL, key_homed_at(MASK_FULL), {$urandom, $urandom});
        issue_write(MASK_NONE, lowbias_hash(u), '0);
        issue_lookup(u);
        // key word all ones and the largest ordinary uid
        issue_write(10'd512, '1, '1);
        issue_lookup(rhul_pkg::UID_NONE - 1'b1);
    endtask

    // mask zero pins every probe to slot zero, so a foreign key runs to the probe cap
    task automatic test_probe_cap();
        logic [rhul_pkg::UID_W-1:0] u;
        logic [rhul_pkg::KEY_W-1:0] h;
        set_index_mask(MASK_NONE);
        u = uid_homed_at(MASK_NONE);
        h = lowbias_hash(u);
        issue_write(MASK_NONE, (h ^ 32'd1) | 32'd2, {$urandom, $urandom});
        issue_lookup(u);
        issue_write(MASK_NONE, h, {$urandom, $urandom});
        issue_lookup(u);
    endtask

    // mostly well-formed inserts and lookups of stored uids, some noise
    task automatic test_table_traffic(input logic [rhul_pkg::MASK_W-1:0] mask, input int items);
        logic [rhul_pkg::UID_W-1:0] u;
        int pick;
        int capacity;
        set_index_mask(mask);
        known_uids.delete();
        for (int s = 0; s < TABLE_SLOTS; s++)
            if ((s[rhul_pkg::MASK_W-1:0] & mask) == s[rhul_pkg::MASK_W-1:0] && key_tbl[s] != '0)
                issue_write(s[rhul_pkg::MASK_W-1:0], '0, {$urandom, $urandom});
        capacity = ((1 << $countones(mask)) * 7) / 10;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 45 && occupied_slots() < capacity) begin
                do u = $urandom; while (u == rhul_pkg::UID_NONE);
                rh_insert(u, {$urandom, $urandom});
                known_uids.push_back(u);
            end else if (pick < 75 && known_uids.size() != 0) begin
                issue_lookup(known_uids[$urandom_range(known_uids.size() - 1)]);
            end else if (pick < 90) begin
                issue_lookup($urandom);
            end else if (pick < 96) begin
                issue_write(random_slot(), $urandom, {$urandom, $urandom});
            end else if (pick < 98) begin
                issue_lookup(rhul_pkg::UID_NONE);
            end else begin
                hold_until_answered(0);
            end
        end
    endtask

    // receiver stalls
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // compare each accepted answer with the oldest prediction
    always @(posedge aclk) begin
        lookup_answer_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("answer with no lookup waiting", m_tdata, '0);
            end else begin
                want = pending_answers.pop_front();
                answers_checked++;
                if (m_tuser !== want.found)
                    report_mismatch("found flag", 64'(m_tuser), 64'(want.found));
                if (m_tdata !== want.value)
                    report_mismatch("value", m_tdata, want.value);
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 16;
        recv_idle_pct = 84;
        test_lookup_basics();
        test_probe_cap();
        test_table_traffic(10'd15, 50);
        test_table_traffic(10'd255, 100);

        send_idle_pct = 84;
        recv_idle_pct = 16;
        test_table_traffic(10'd63, 80);
        test_table_traffic(10'd5, 40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_table_traffic(MASK_FULL, 110);
        test_table_traffic(10'd31, 80);

        hold_until_answered(DRAIN_CYCLES);
        if (pending_answers.size() != 0)
            report_mismatch("lookups left unanswered", 64'(pending_answers.size()), '0);

        $display("covered %0d requests over %0d mask settings, including the probe cap",
                 requests_sent, mask_writes);
        $display("checked %0d lookup answers, %0d of them hits", answers_checked,
                 hits_expected);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rhul_pkg.sv
rtl/rhul_hash.sv
rtl/robin_hood_uid_lookup_unit.sv
sim/testbench.sv
